/* sv/rgbs_pkg.sv */
// ----------------------------------------------------------------------------
// rgbs_pkg
// Shared constants and types for the running Gaussian background subtractor.
// ----------------------------------------------------------------------------
package rgbs_pkg;

   localparam int PixelsDefault   = 32768;
   localparam int FracBitsDefault = 8;
   localparam int IndexWidth      = 15;
   localparam int CsrAddrWidth    = 4;

   localparam logic [CsrAddrWidth-1:0] CsrBlendRate  = 4'h0;
   localparam logic [CsrAddrWidth-1:0] CsrDevMultiple = 4'h4;
   localparam logic [CsrAddrWidth-1:0] CsrDevFloor   = 4'h8;
   localparam logic [CsrAddrWidth-1:0] CsrInitDev    = 4'hC;

   localparam logic OpUpdate = 1'b0;
   localparam logic OpInit   = 1'b1;

   typedef struct packed {
      logic [15:0] blend_rate;
      logic [11:0] deviation_multiple;
      logic [15:0] deviation_floor;
      logic [15:0] initial_deviation;
   } cfg_type;

endpackage

/* sv/rgbs_req_if.sv */
// ----------------------------------------------------------------------------
// rgbs_req_if
// Pixel transaction channel: operation, index and RGB samples.
// ----------------------------------------------------------------------------
interface rgbs_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [14:0] pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   modport source (output valid, op, pixel_index, red, green, blue, input ready);
   modport sink   (input valid, op, pixel_index, red, green, blue, output ready);
endinterface

/* sv/rgbs_rsp_if.sv */
// ----------------------------------------------------------------------------
// rgbs_rsp_if
// Result transaction channel: foreground flag and background color.
// ----------------------------------------------------------------------------
interface rgbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       foreground;
   logic [7:0] background_red;
   logic [7:0] background_green;
   logic [7:0] background_blue;
   modport source (output valid, foreground, background_red, background_green,
                   background_blue, input ready);
   modport sink   (input valid, foreground, background_red, background_green,
                   background_blue, output ready);
endinterface

/* sv/rgbs_csr.sv */
// ----------------------------------------------------------------------------
// rgbs_csr
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module rgbs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rgbs_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output rgbs_pkg::cfg_type                  cfg
);
   import rgbs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (paddr)
            CsrBlendRate:   cfg_in.blend_rate         = pwdata[15:0];
            CsrDevMultiple: cfg_in.deviation_multiple = pwdata[11:0];
            CsrDevFloor:    cfg_in.deviation_floor    = pwdata[15:0];
            CsrInitDev:     cfg_in.initial_deviation  = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         CsrBlendRate:   prdata = {16'd0, cfg_ff.blend_rate};
         CsrDevMultiple: prdata = {20'd0, cfg_ff.deviation_multiple};
         CsrDevFloor:    prdata = {16'd0, cfg_ff.deviation_floor};
         CsrInitDev:     prdata = {16'd0, cfg_ff.initial_deviation};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd66, 12'd717, 16'd1024, 16'd2560};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* sv/rgbs_sqrt.sv */
// ----------------------------------------------------------------------------
// rgbs_sqrt
// Pipelined rounded square root, two result bits per stage.
// ----------------------------------------------------------------------------
module rgbs_sqrt #(
   parameter int InWidth = 32,
   parameter int Tag     = 1
) (
   input  logic                         clock,
   input  logic [InWidth-1:0]           value,
   input  logic [Tag-1:0]               tag_i,
   output logic [(InWidth+1)/2:0]       root,
   output logic [Tag-1:0]               tag_o
);
   localparam int Half   = (InWidth + 1) / 2;
   localparam int W2     = 2 * Half;
   localparam int Stages = (Half + 1) / 2;
   localparam int RemW   = Half + 2;

   logic [W2-1:0]   rad_ff [Stages+1];
   logic [Half-1:0] res_ff [Stages+1];
   logic [RemW-1:0] rem_ff [Stages+1];
   logic [Tag-1:0]  tag_ff [Stages+1];

   always_ff @(posedge clock) begin
      rad_ff[0] <= W2'(value);
      res_ff[0] <= '0;
      rem_ff[0] <= '0;
      tag_ff[0] <= tag_i;
   end

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [W2-1:0]   rad;
      logic [Half-1:0] res;
      logic [RemW-1:0] rem;
      always_comb begin
         logic [RemW-1:0] trial;
         rad = rad_ff[s];
         res = res_ff[s];
         rem = rem_ff[s];
         for (int k = 0; k < 2; k++) begin
            if (2 * s + k < Half) begin
               rem   = {rem[RemW-3:0], rad[W2-1 -: 2]};
               rad   = {rad[W2-3:0], 2'b00};
               trial = {res, 2'b01};
               if (rem >= trial) begin
                  rem = rem - trial;
                  res = {res[Half-2:0], 1'b1};
               end else begin
                  res = {res[Half-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         rad_ff[s+1] <= rad;
         res_ff[s+1] <= res;
         rem_ff[s+1] <= rem;
         tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign root  = {1'b0, res_ff[Stages]} +
                  ((rem_ff[Stages] > RemW'(res_ff[Stages])) ? (Half+1)'(1) : '0);
   assign tag_o = tag_ff[Stages];
endmodule

/* sv/rgbs_datapath.sv */
// ----------------------------------------------------------------------------
// rgbs_datapath
// Per-channel model update: threshold test, mean blend, variance blend.
// Pipeline: P0 diff/products, P1 blend products, P2 blend sums, sqrt stages, then floor/round.
// ----------------------------------------------------------------------------
module rgbs_datapath #(
   parameter int FracBits = 8,
   parameter int Tag      = 1
) (
   input  logic                   clock,
   input  rgbs_pkg::cfg_type      cfg,
   input  logic [7:0]             sample,
   input  logic [8+FracBits-1:0]  mean,
   input  logic [8+FracBits-1:0]  dev,
   input  logic [Tag-1:0]         tag_i,
   output logic                   fg,
   output logic [8+FracBits-1:0]  mean_new,
   output logic [8+FracBits-1:0]  dev_new,
   output logic [7:0]             bg,
   output logic [Tag-1:0]         tag_o
);
   localparam int V  = 8 + FracBits;
   localparam int SQ = 2 * V;
   localparam int WW = SQ + 1;
   localparam int Up = (FracBits >= 8) ? FracBits - 8 : 0;
   localparam int Dn = (FracBits >= 8) ? 0 : 8 - FracBits;
   localparam int Half = (WW + 1) / 2;

   logic [V-1:0]  x;
   logic [V-1:0]  d;
   assign x = {sample, FracBits'(0)};
   assign d = (x > mean) ? x - mean : mean - x;

   // stage 1: products
   logic [V-1:0]    x1_ff, m1_ff;
   logic [SQ-1:0]   ss1_ff, dd1_ff;
   logic            fg1_ff;
   logic [16:0]     keep1_ff;
   logic [15:0]     a1_ff;
   logic [V-1:0]    floor1_ff;
   logic [Tag-1:0]  tag1_ff;

   always_ff @(posedge clock) begin
      x1_ff     <= x;
      m1_ff     <= mean;
      ss1_ff    <= dev * dev;
      dd1_ff    <= d * d;
      fg1_ff    <= ({4'd0, d, 8'd0} > ((V+12)'(cfg.deviation_multiple) * (V+12)'(dev)));
      a1_ff     <= cfg.blend_rate;
      keep1_ff  <= 17'h10000 - {1'b0, cfg.blend_rate};
      floor1_ff <= V'((32'(cfg.deviation_floor) << Up) >> Dn);
      tag1_ff   <= tag_i;
   end

   // stage 2: blends
   logic [V+17:0]   mp2a_ff, mp2b_ff;
   logic [SQ+17:0]  wp2a_ff, wp2b_ff;
   logic            fg2_ff;
   logic [V-1:0]    floor2_ff;
   logic [Tag-1:0]  tag2_ff;

   always_ff @(posedge clock) begin
      mp2a_ff   <= (V+18)'(m1_ff) * (V+18)'(keep1_ff);
      mp2b_ff   <= (V+18)'(x1_ff) * (V+18)'(a1_ff);
      wp2a_ff   <= (SQ+18)'(ss1_ff) * (SQ+18)'(keep1_ff);
      wp2b_ff   <= (SQ+18)'(dd1_ff) * (SQ+18)'(a1_ff);
      fg2_ff    <= fg1_ff;
      floor2_ff <= floor1_ff;
      tag2_ff   <= tag1_ff;
   end

   logic [V+18:0]  msum;
   logic [SQ+18:0] wsum;
   logic [V+2:0]   mn_w;
   assign msum = (V+19)'(mp2a_ff) + (V+19)'(mp2b_ff) + (V+19)'(32768);
   assign wsum = (SQ+19)'(wp2a_ff) + (SQ+19)'(wp2b_ff) + (SQ+19)'(32768);
   assign mn_w = msum[V+18:16];

   logic [V-1:0]   mn3_ff;
   logic [WW-1:0]  w3_ff;
   logic           fg3_ff;
   logic [V-1:0]   floor3_ff;
   logic [Tag-1:0] tag3_ff;

   always_ff @(posedge clock) begin
      mn3_ff    <= (mn_w > (V+3)'({V{1'b1}})) ? {V{1'b1}} : mn_w[V-1:0];
      w3_ff     <= wsum[SQ+16:16];
      fg3_ff    <= fg2_ff;
      floor3_ff <= floor2_ff;
      tag3_ff   <= tag2_ff;
   end

   localparam int SideW = 1 + V + V + Tag;
   logic [Half:0]      root;
   logic [SideW-1:0]   side;
   logic [SideW-1:0]   side_o;
   assign side = {fg3_ff, mn3_ff, floor3_ff, tag3_ff};

   rgbs_sqrt #(.InWidth(WW), .Tag(SideW)) u_sqrt (
      .clock (clock),
      .value (w3_ff),
      .tag_i (side),
      .root  (root),
      .tag_o (side_o)
   );

   logic [V-1:0] mn_o, fl_o, sat;
   logic [V:0]   bgs;
   assign {fg, mn_o, fl_o, tag_o} = side_o;
   assign sat = (root > (Half+1)'({V{1'b1}})) ? {V{1'b1}} : root[V-1:0];
   assign dev_new  = (sat < fl_o) ? fl_o : sat;
   assign mean_new = mn_o;
   assign bgs = ({1'b0, mn_o} + (V+1)'(1 << (FracBits - 1))) >> FracBits;
   assign bg  = (bgs > (V+1)'(255)) ? 8'd255 : bgs[7:0];
endmodule

/* sv/running_gaussian_background_subtract_unit.sv */
// ----------------------------------------------------------------------------
// running_gaussian_background_subtract_unit
// Per-pixel running Gaussian background model with foreground flag.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock unless held by a hazard or by output
// backpressure, and returns one result per in-range pixel through the memory
// read, three arithmetic stages, the pipelined square root, the result queue
// and the output register. Means and deviations live in two single-port-write
// memories; a pixel whose entry was written back after its read takes the
// newest value from a forwarding path over recent write-backs, and a pixel
// whose entry is still inside the arithmetic pipeline is held at the input
// until that write-back. Indexes at or above PIXELS are dropped without a
// result. Pixels must be initialized before their first update. Output
// backpressure stalls the input; items already in the arithmetic pipeline
// drain into the result queue.
module running_gaussian_background_subtract_unit #(
   parameter int PIXELS    = rgbs_pkg::PixelsDefault,
   parameter int FRAC_BITS = rgbs_pkg::FracBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   rgbs_req_if.sink                          req,
   rgbs_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rgbs_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import rgbs_pkg::*;

   localparam int V    = 8 + FRAC_BITS;
   localparam int AW   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int WW   = 2 * V + 1;
   localparam int Half = (WW + 1) / 2;
   localparam int SqS  = (Half + 1) / 2;
   localparam int Lat  = 3 + SqS + 1;   // datapath latency
   localparam int Up   = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
   localparam int Dn   = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
   localparam int TagW = AW;

   cfg_type cfg;
   rgbs_csr u_csr (
      .clock (clock), .reset (reset),
      .psel (csr_psel), .penable (csr_penable), .pwrite (csr_pwrite),
      .paddr (csr_paddr), .pwdata (csr_pwdata), .prdata (csr_prdata),
      .pready (csr_pready), .cfg (cfg)
   );

   // input side advances when the output register can take data
   logic adv;
   logic out_v_ff;
   logic hz;
   logic r_go;
   assign adv       = !out_v_ff || rsp.ready;
   assign r_go      = adv && !hz;
   assign req.ready = r_go;

   logic take;
   assign take = req.valid && r_go && (32'(req.pixel_index) < PIXELS);

   logic [3*V-1:0] mean_mem [PIXELS];
   logic [3*V-1:0] dev_mem  [PIXELS];
   logic [3*V-1:0] mrd_ff, drd_ff;

   // stage R: memory read
   logic           r_v_ff, r_op_ff;
   logic [AW-1:0]  r_idx_ff;
   logic [23:0]    r_px_ff;
   logic [V-1:0]   r_init_ff;

   // write-back from the end of the datapath
   logic           wb_v;
   logic [AW-1:0]  wb_idx;
   logic [3*V-1:0] wb_m, wb_d;

   // in-flight history of recent write-backs for forwarding
   logic           h_v_ff   [Lat+1];
   logic [AW-1:0]  h_idx_ff [Lat+1];
   logic [3*V-1:0] h_m_ff   [Lat+1];
   logic [3*V-1:0] h_d_ff   [Lat+1];

   // items inside the arithmetic pipeline
   logic           p_v_ff   [Lat];
   logic [AW-1:0]  p_idx_ff [Lat];

   // newest of (write-back, history, memory read)
   logic [3*V-1:0] m_fwd, d_fwd;
   always_comb begin
      m_fwd = mrd_ff;
      d_fwd = drd_ff;
      for (int k = Lat; k >= 0; k--) begin
         if (h_v_ff[k] && h_idx_ff[k] == r_idx_ff) begin
            m_fwd = h_m_ff[k];
            d_fwd = h_d_ff[k];
         end
      end
      if (wb_v && wb_idx == r_idx_ff) begin
         m_fwd = wb_m;
         d_fwd = wb_d;
      end
   end

   // hold a pixel whose entry is still being computed
   always_comb begin
      hz = 1'b0;
      for (int k = 0; k < Lat - 1; k++) begin
         if (p_v_ff[k] && p_idx_ff[k] == r_idx_ff) hz = 1'b1;
      end
      hz = hz && r_v_ff;
   end

   always_ff @(posedge clock) begin
      if (r_go) begin
         mrd_ff    <= mean_mem[AW'(req.pixel_index)];
         drd_ff    <= dev_mem[AW'(req.pixel_index)];
         r_op_ff   <= req.op;
         r_idx_ff  <= AW'(req.pixel_index);
         r_px_ff   <= {req.red, req.green, req.blue};
         r_init_ff <= V'((32'(cfg.initial_deviation) << Up) >> Dn);
      end else begin
         mrd_ff    <= m_fwd;
         drd_ff    <= d_fwd;
      end
      if (wb_v) begin
         mean_mem[wb_idx] <= wb_m;
         dev_mem[wb_idx]  <= wb_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (r_go) begin
         r_v_ff <= take;
      end
   end

   // operand select
   logic [3*V-1:0] m_sel, d_sel;
   always_comb begin
      m_sel = m_fwd;
      d_sel = d_fwd;
      if (r_op_ff == OpInit) begin
         m_sel = {r_px_ff[23:16], FRAC_BITS'(0), r_px_ff[15:8], FRAC_BITS'(0),
                  r_px_ff[7:0], FRAC_BITS'(0)};
         d_sel = {r_init_ff, r_init_ff, r_init_ff};
      end
   end

   // datapath lanes run freely; the result queue absorbs what is in flight
   logic [2:0]    fg_l;
   logic [V-1:0]  mn_l [3];
   logic [V-1:0]  dn_l [3];
   logic [7:0]    bg_l [3];
   logic [TagW-1:0] tag_l [3];
   logic [TagW-1:0] tag_in;
   assign tag_in = r_idx_ff;

   for (genvar c = 0; c < 3; c++) begin : g_lane
      rgbs_datapath #(.FracBits(FRAC_BITS), .Tag(TagW)) u_dp (
         .clock    (clock),
         .cfg      (cfg),
         .sample   (r_px_ff[23-8*c -: 8]),
         .mean     (m_sel[3*V-1-V*c -: V]),
         .dev      (d_sel[3*V-1-V*c -: V]),
         .tag_i    (tag_in),
         .fg       (fg_l[c]),
         .mean_new (mn_l[c]),
         .dev_new  (dn_l[c]),
         .bg       (bg_l[c]),
         .tag_o    (tag_l[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Lat; k++) p_v_ff[k] <= 1'b0;
      end else begin
         p_v_ff[0] <= r_v_ff && r_go;
         for (int k = 1; k < Lat; k++) p_v_ff[k] <= p_v_ff[k-1];
      end
      p_idx_ff[0] <= r_idx_ff;
      for (int k = 1; k < Lat; k++) p_idx_ff[k] <= p_idx_ff[k-1];
   end

   assign wb_v   = p_v_ff[Lat-1];
   assign wb_idx = tag_l[0];
   assign wb_m   = {mn_l[0], mn_l[1], mn_l[2]};
   assign wb_d   = {dn_l[0], dn_l[1], dn_l[2]};

   // history shift line (entries 0..Lat hold write-backs already committed to memory)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Lat; k++) h_v_ff[k] <= 1'b0;
      end else begin
         h_v_ff[0] <= wb_v;
         for (int k = 1; k <= Lat; k++) h_v_ff[k] <= h_v_ff[k-1];
      end
      h_idx_ff[0] <= wb_idx;
      h_m_ff[0]   <= wb_m;
      h_d_ff[0]   <= wb_d;
      for (int k = 1; k <= Lat; k++) begin
         h_idx_ff[k] <= h_idx_ff[k-1];
         h_m_ff[k]   <= h_m_ff[k-1];
         h_d_ff[k]   <= h_d_ff[k-1];
      end
   end

   // result FIFO: lanes do not stall, so results land in a queue sized to
   // cover everything in flight
   localparam int QD  = 1 << $clog2(Lat + 4);
   localparam int QAW = $clog2(QD);
   logic [24:0]  q_mem [QD];
   logic [QAW:0] wp_ff, rp_ff, cnt;
   assign cnt = wp_ff - rp_ff;

   always_ff @(posedge clock) begin
      if (wb_v) q_mem[wp_ff[QAW-1:0]] <= {|fg_l, bg_l[0], bg_l[1], bg_l[2]};
   end

   logic [24:0] out_ff;
   logic        pop;
   assign pop = (cnt != '0) && (!out_v_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (wb_v) wp_ff <= wp_ff + 1'b1;
         if (pop) begin
            rp_ff    <= rp_ff + 1'b1;
            out_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_v_ff <= 1'b0;
         end
      end
      if (pop) out_ff <= q_mem[rp_ff[QAW-1:0]];
   end

   assign rsp.valid            = out_v_ff;
   assign rsp.foreground       = out_ff[24];
   assign rsp.background_red   = out_ff[23:16];
   assign rsp.background_green = out_ff[15:8];
   assign rsp.background_blue  = out_ff[7:0];
endmodule
